// ----- hw/rtl/ccrs_pkg.sv -----
// Shared types, widths and constants of the coverage-capped read selector.
`default_nettype none

package ccrs_pkg;

   // Field widths
   localparam int FRAG_W  = 20;
   localparam int MAPQ_W  = 8;
   localparam int IDENT_W = 14;
   localparam int COV_W   = 8;
   localparam int SPAN_W  = 21;
   localparam int BASE_W  = 28;
   localparam int GOAL_W  = SPAN_W + COV_W;
   localparam int VERD_W  = 3;
   localparam int CSRI_W  = 3;
   localparam int CSRD_W  = 21;

   // Storage depth default
   localparam int DEFAULT_STORE_POSITIONS = 1048576;

   // Coverage rules
   localparam logic [COV_W-1:0]  COVERAGE_CEILING = COV_W'(200);
   localparam int                FREE_W           = 5;
   localparam logic [FREE_W-1:0] MIN_FREE         = FREE_W'(20);
   localparam logic [BASE_W-1:0] BASE_MAX         = {BASE_W{1'b1}};

   // Register reset values
   localparam logic [FRAG_W-1:0]  RST_MIN_FRAG  = FRAG_W'(100);
   localparam logic [MAPQ_W-1:0]  RST_MIN_MAPQ  = MAPQ_W'(5);
   localparam logic [IDENT_W-1:0] RST_MIN_IDENT = IDENT_W'(9000);
   localparam logic [COV_W-1:0]   RST_TARGET    = COV_W'(30);
   localparam logic [SPAN_W-1:0]  RST_CHROM_LEN = SPAN_W'(1048576);

   typedef enum logic [CSRI_W-1:0] {
      CSR_MIN_FRAG  = 3'd0,
      CSR_MIN_MAPQ  = 3'd1,
      CSR_MIN_IDENT = 3'd2,
      CSR_TARGET    = 3'd3,
      CSR_CHROM_LEN = 3'd4
   } csr_index_type;

   typedef enum logic [VERD_W-1:0] {
      VERDICT_ACCEPTED = 3'd0,
      VERDICT_QUALITY  = 3'd1,
      VERDICT_FULL     = 3'd2,
      VERDICT_TARGET   = 3'd3,
      VERDICT_CLEARED  = 3'd4
   } verdict_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_UPDATE,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/coverage_capped_read_selector_top.sv -----
// Coverage-capped read selector: top level with control sequencer and registers.
//   req_* carries one transaction per read offer (opcode 0) or start command
//   (opcode 1); it is taken when req_valid is high and req_stall low. Every
//   transaction yields exactly one rsp_* transaction (verdict, target flag,
//   accepted base count), taken when rsp_valid is high and rsp_stall low.
//   csr_* writes one configuration register per csr_valid/csr_ready cycle;
//   csr_ready is always high. Write registers only while the block is idle.
//   A read that passes the filters walks its clipped span through the
//   coverage memory twice (count pass, then increment pass), one position a
//   cycle; the increment pass is skipped if the count pass finds too few
//   free positions. Reads rejected by the target or quality checks, or with
//   an empty span, skip both passes. A start command sweeps the whole
//   memory. One transaction is in flight at a time; req_stall is high while
//   it runs, and the next one is taken in the cycle after its result is
//   loaded into the output register.
//   After reset a clearing pass writes zero to all STORE_POSITIONS entries,
//   one per cycle, with req_stall held high; configuration writes are taken.
//   A stalled result is held in the output register; the next transaction
//   is accepted meanwhile and waits at its end until the register frees.
`default_nettype none

module coverage_capped_read_selector_top
   import ccrs_pkg::*;
#(
   parameter int STORE_POSITIONS = DEFAULT_STORE_POSITIONS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_opcode,
   input  wire logic [FRAG_W-1:0]   req_fragment_length,
   input  wire logic [MAPQ_W-1:0]   req_mapping_quality,
   input  wire logic [IDENT_W-1:0]  req_identity_centi,
   input  wire logic [SPAN_W-1:0]   req_span_start,
   input  wire logic [SPAN_W-1:0]   req_span_end,
   // response channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [VERD_W-1:0]   rsp_verdict,
   output logic                     rsp_target_reached,
   output logic      [BASE_W-1:0]   rsp_accepted_bases,
   // configuration channel
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CSRI_W-1:0]   csr_index,
   input  wire logic [CSRD_W-1:0]   csr_wdata
);

   localparam int AW = $clog2(STORE_POSITIONS);
   localparam int LW = (AW + 1 > SPAN_W) ? AW + 1 : SPAN_W;
   localparam logic [LW-1:0] STORE_LIM  = LW'(STORE_POSITIONS);
   localparam logic [LW-1:0] CLEAR_LAST = LW'(STORE_POSITIONS - 1);

   // Configuration registers
   logic [FRAG_W-1:0]  min_frag_ff;
   logic [MAPQ_W-1:0]  min_mapq_ff;
   logic [IDENT_W-1:0] min_ident_ff;
   logic [COV_W-1:0]   target_ff;
   logic [SPAN_W-1:0]  chrom_len_ff;
   logic [GOAL_W-1:0]  goal;

   // Control state
   state_type          state_ff, state_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic               pend_ff, pend_in;
   logic [FREE_W-1:0]  free_ff, free_in;
   logic [BASE_W-1:0]  base_ff, base_in;
   logic               done_ff, done_in;
   verdict_type        verdict_ff, verdict_in;

   // Working registers
   logic [LW-1:0]      addr_ff, addr_in;
   logic [LW-1:0]      end_ff, end_in;
   logic [LW-1:0]      start_ff, start_in;
   logic [AW-1:0]      wr_addr_ff;
   logic [FRAG_W-1:0]  frag_ff, frag_in;
   logic [MAPQ_W-1:0]  mapq_ff, mapq_in;
   logic [IDENT_W-1:0] ident_ff, ident_in;
   logic [SPAN_W-1:0]  sstart_ff, sstart_in;
   logic [SPAN_W-1:0]  send_ff, send_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   verdict_type        rsp_verdict_ff;
   logic               rsp_reached_ff;
   logic [BASE_W-1:0]  rsp_bases_ff;

   // Memory interface
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic [COV_W-1:0]   mem_wr_data;
   logic               mem_rd_en;
   logic [COV_W-1:0]   mem_rd_data;
   logic [COV_W-1:0]   cov_inc;

   // Decode helpers
   logic               req_take;
   logic               rsp_free;
   logic               issue;
   logic               pass_end;
   logic               target_hit;
   logic               quality_fail;
   logic [LW-1:0]      limit;
   logic [LW-1:0]      chrom_ext;
   logic [LW-1:0]      s_ext;
   logic [LW-1:0]      e_ext;
   logic [LW-1:0]      s_clip;
   logic [LW-1:0]      e_clip;
   logic               span_empty;
   logic [BASE_W:0]    base_sum;
   logic [BASE_W-1:0]  base_new;

   // Handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_frag_ff  <= RST_MIN_FRAG;
         min_mapq_ff  <= RST_MIN_MAPQ;
         min_ident_ff <= RST_MIN_IDENT;
         target_ff    <= RST_TARGET;
         chrom_len_ff <= RST_CHROM_LEN;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_FRAG:  min_frag_ff  <= csr_wdata[FRAG_W-1:0];
            CSR_MIN_MAPQ:  min_mapq_ff  <= csr_wdata[MAPQ_W-1:0];
            CSR_MIN_IDENT: min_ident_ff <= csr_wdata[IDENT_W-1:0];
            CSR_TARGET:    target_ff    <= csr_wdata[COV_W-1:0];
            CSR_CHROM_LEN: chrom_len_ff <= csr_wdata[SPAN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Depth goal from the current settings
   assign goal = GOAL_W'(chrom_len_ff) * GOAL_W'(target_ff);

   // Filter checks and span clipping
   assign target_hit   = done_ff || (GOAL_W'(base_ff) >= goal);
   assign quality_fail = (frag_ff < min_frag_ff) || (mapq_ff < min_mapq_ff) ||
                         (ident_ff < min_ident_ff);
   assign chrom_ext    = LW'(chrom_len_ff);
   assign limit        = (chrom_ext < STORE_LIM) ? chrom_ext : STORE_LIM;
   assign s_ext        = LW'(sstart_ff);
   assign e_ext        = LW'(send_ff);
   assign s_clip       = (s_ext > limit) ? limit : s_ext;
   assign e_clip       = (e_ext > limit) ? limit : e_ext;
   assign span_empty   = (e_clip <= s_clip);

   // Span walk control
   assign issue    = (addr_ff != end_ff);
   assign pass_end = !issue && !pend_ff;

   // Saturating base total
   assign base_sum = {1'b0, base_ff} + (BASE_W + 1)'(frag_ff);
   assign base_new = base_sum[BASE_W] ? BASE_MAX : base_sum[BASE_W-1:0];

   // Saturating coverage increment
   assign cov_inc = (mem_rd_data < COVERAGE_CEILING) ? mem_rd_data + COV_W'(1) : mem_rd_data;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (addr_ff == CLEAR_LAST) begin
               state_in = clr_rsp_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               state_in = req_opcode ? ST_CLEAR : ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (target_hit || quality_fail || span_empty) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pass_end) begin
               state_in = (free_ff < MIN_FREE) ? ST_RESP : ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (pass_end) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath updates per state
   always_comb begin
      clr_rsp_in = clr_rsp_ff;
      pend_in    = 1'b0;
      free_in    = free_ff;
      base_in    = base_ff;
      done_in    = done_ff;
      verdict_in = verdict_ff;
      addr_in    = addr_ff;
      end_in     = end_ff;
      start_in   = start_ff;
      frag_in    = frag_ff;
      mapq_in    = mapq_ff;
      ident_in   = ident_ff;
      sstart_in  = sstart_ff;
      send_in    = send_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            addr_in    = addr_ff + LW'(1);
            verdict_in = VERDICT_CLEARED;
            if (addr_ff == CLEAR_LAST) begin
               clr_rsp_in = 1'b0;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               frag_in   = req_fragment_length;
               mapq_in   = req_mapping_quality;
               ident_in  = req_identity_centi;
               sstart_in = req_span_start;
               send_in   = req_span_end;
               if (req_opcode) begin
                  addr_in    = '0;
                  clr_rsp_in = 1'b1;
                  base_in    = '0;
                  done_in    = 1'b0;
               end
            end
         end
         ST_CHECK: begin
            addr_in  = s_clip;
            start_in = s_clip;
            end_in   = e_clip;
            free_in  = '0;
            if (target_hit) begin
               done_in    = 1'b1;
               verdict_in = VERDICT_TARGET;
            end else if (quality_fail) begin
               verdict_in = VERDICT_QUALITY;
            end else if (span_empty) begin
               verdict_in = VERDICT_FULL;
            end
         end
         ST_SCAN: begin
            // count positions below the cap, saturating at the threshold
            if (issue) begin
               addr_in = addr_ff + LW'(1);
               pend_in = 1'b1;
            end
            if (pend_ff && (mem_rd_data < target_ff) && (free_ff < MIN_FREE)) begin
               free_in = free_ff + FREE_W'(1);
            end
            if (pass_end) begin
               addr_in = start_ff;
               if (free_ff < MIN_FREE) begin
                  verdict_in = VERDICT_FULL;
               end
            end
         end
         ST_UPDATE: begin
            if (issue) begin
               addr_in = addr_ff + LW'(1);
               pend_in = 1'b1;
            end
            if (pass_end) begin
               base_in    = base_new;
               done_in    = (GOAL_W'(base_new) >= goal);
               verdict_in = VERDICT_ACCEPTED;
            end
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // Memory port drive
   always_comb begin
      mem_rd_en   = ((state_ff == ST_SCAN) || (state_ff == ST_UPDATE)) && issue;
      mem_wr_en   = (state_ff == ST_CLEAR) || ((state_ff == ST_UPDATE) && pend_ff);
      mem_wr_addr = (state_ff == ST_CLEAR) ? addr_ff[AW-1:0] : wr_addr_ff;
      mem_wr_data = (state_ff == ST_CLEAR) ? '0 : cov_inc;
   end

   // Output register: load on completion, drop when taken
   always_comb begin
      if ((state_ff == ST_RESP) && rsp_free) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_rsp_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         base_ff      <= '0;
         done_ff      <= 1'b0;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_rsp_ff   <= clr_rsp_in;
         pend_ff      <= pend_in;
         base_ff      <= base_in;
         done_ff      <= done_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      free_ff    <= free_in;
      verdict_ff <= verdict_in;
      end_ff     <= end_in;
      start_ff   <= start_in;
      wr_addr_ff <= addr_ff[AW-1:0];
      frag_ff    <= frag_in;
      mapq_ff    <= mapq_in;
      ident_ff   <= ident_in;
      sstart_ff  <= sstart_in;
      send_ff    <= send_in;
      if ((state_ff == ST_RESP) && rsp_free) begin
         rsp_verdict_ff <= verdict_ff;
         rsp_reached_ff <= done_ff;
         rsp_bases_ff   <= base_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_verdict        = rsp_verdict_ff;
   assign rsp_target_reached = rsp_reached_ff;
   assign rsp_accepted_bases = rsp_bases_ff;

   // Coverage memory
   ccrs_store #(
      .DEPTH  (STORE_POSITIONS),
      .ADDR_W (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/ccrs_store.sv -----
// Per-position coverage memory: one write port, one registered read port.
`default_nettype none

module ccrs_store
   import ccrs_pkg::*;
#(
   parameter int DEPTH  = DEFAULT_STORE_POSITIONS,
   parameter int ADDR_W = $clog2(DEFAULT_STORE_POSITIONS)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [COV_W-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [COV_W-1:0]  rd_data
);

   logic [COV_W-1:0] mem [DEPTH];
   logic [COV_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- verif/coverage_capped_read_selector_top_tb.sv -----
// Self-checking testbench for the coverage-capped read selector top level.
`default_nettype none

module coverage_capped_read_selector_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ccrs_pkg::*;

   // A small coverage memory keeps start commands and the clearing pass short
   localparam int STORE_DEPTH = 1024;
   localparam int TAIL_CYCLES = 60;

   typedef struct {
      bit                  opcode;
      logic [FRAG_W-1:0]   frag;
      logic [MAPQ_W-1:0]   mapq;
      logic [IDENT_W-1:0]  ident;
      logic [SPAN_W-1:0]   span_start;
      logic [SPAN_W-1:0]   span_end;
   } read_cmd_type;

   typedef struct {
      verdict_type         verdict;
      logic                reached;
      logic [BASE_W-1:0]   bases;
   } verdict_rec_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_opcode;
   logic [FRAG_W-1:0]   req_fragment_length;
   logic [MAPQ_W-1:0]   req_mapping_quality;
   logic [IDENT_W-1:0]  req_identity_centi;
   logic [SPAN_W-1:0]   req_span_start;
   logic [SPAN_W-1:0]   req_span_end;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [VERD_W-1:0]   rsp_verdict;
   logic                rsp_target_reached;
   logic [BASE_W-1:0]   rsp_accepted_bases;
   logic                csr_valid;
   logic                csr_ready;
   csr_index_type       csr_index;
   logic [CSRD_W-1:0]   csr_wdata;

   // Predicted state of the selector
   logic [COV_W-1:0]    cov_depth [STORE_DEPTH];
   longint unsigned     base_sum;
   bit                  goal_met;
   int unsigned         cfg_min_frag;
   int unsigned         cfg_min_mapq;
   int unsigned         cfg_min_ident;
   int unsigned         cfg_target;
   int unsigned         cfg_chrom_len;

   verdict_rec_type     pending_verdicts [$];
   int                  mismatches;
   bit                  calm;

   coverage_capped_read_selector_top #(
      .STORE_POSITIONS (STORE_DEPTH)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_fragment_length (req_fragment_length),
      .req_mapping_quality (req_mapping_quality),
      .req_identity_centi  (req_identity_centi),
      .req_span_start      (req_span_start),
      .req_span_end        (req_span_end),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_verdict         (rsp_verdict),
      .rsp_target_reached  (rsp_target_reached),
      .rsp_accepted_bases  (rsp_accepted_bases),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Work out the verdict of one transaction and advance the predicted state
   function automatic verdict_rec_type predict_verdict(read_cmd_type cmd);
      verdict_rec_type rec;
      longint unsigned goal;
      int unsigned     lim;
      int unsigned     lo;
      int unsigned     hi;
      int unsigned     full;
      goal = longint'(cfg_chrom_len) * longint'(cfg_target);
      if (cmd.opcode) begin
         foreach (cov_depth[i]) cov_depth[i] = '0;
         base_sum = 0;
         goal_met = 1'b0;
         rec.verdict = VERDICT_CLEARED;
      end else if (goal_met || base_sum >= goal) begin
         goal_met = 1'b1;
         rec.verdict = VERDICT_TARGET;
      end else if (cmd.frag < cfg_min_frag || cmd.mapq < cfg_min_mapq ||
                   cmd.ident < cfg_min_ident) begin
         rec.verdict = VERDICT_QUALITY;
      end else begin
         // clip both ends to the chromosome and the memory
         lim = (cfg_chrom_len < STORE_DEPTH) ? cfg_chrom_len : STORE_DEPTH;
         lo = (cmd.span_start > lim) ? lim : cmd.span_start;
         hi = (cmd.span_end > lim) ? lim : cmd.span_end;
         full = 0;
         for (int p = lo; p < hi; p++)
            if (cov_depth[p] >= cfg_target) full++;
         if (hi <= lo || (hi - lo) - full < MIN_FREE) begin
            rec.verdict = VERDICT_FULL;
         end else begin
            for (int p = lo; p < hi; p++)
               if (cov_depth[p] < COVERAGE_CEILING) cov_depth[p]++;
            if (base_sum + cmd.frag > BASE_MAX) base_sum = BASE_MAX;
            else base_sum = base_sum + cmd.frag;
            if (base_sum >= goal) goal_met = 1'b1;
            rec.verdict = VERDICT_ACCEPTED;
         end
      end
      rec.reached = goal_met;
      rec.bases = BASE_W'(base_sum);
      return rec;
   endfunction

   function automatic read_cmd_type make_read(int unsigned frag, int unsigned mapq,
                                              int unsigned ident, int unsigned s,
                                              int unsigned e);
      read_cmd_type cmd;
      cmd.opcode = 1'b0;
      cmd.frag = FRAG_W'(frag);
      cmd.mapq = MAPQ_W'(mapq);
      cmd.ident = IDENT_W'(ident);
      cmd.span_start = SPAN_W'(s);
      cmd.span_end = SPAN_W'(e);
      return cmd;
   endfunction

   // Start command: the read fields carry random junk that must be ignored
   function automatic read_cmd_type make_start();
      read_cmd_type cmd;
      cmd = make_read($urandom_range(0, 1048575), $urandom_range(0, 255),
                      $urandom_range(0, 10000), $urandom_range(0, 1048576),
                      $urandom_range(0, 1048576));
      cmd.opcode = 1'b1;
      return cmd;
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Send one transaction, then record its expected result
   task automatic offer_cmd(input read_cmd_type cmd, output verdict_type verdict);
      verdict_rec_type rec;
      int              gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock) req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_opcode = cmd.opcode;
      req_fragment_length = cmd.frag;
      req_mapping_quality = cmd.mapq;
      req_identity_centi = cmd.ident;
      req_span_start = cmd.span_start;
      req_span_end = cmd.span_end;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      rec = predict_verdict(cmd);
      pending_verdicts.push_back(rec);
      verdict = rec.verdict;
   endtask

   // Hold off the sender until every expected result has come back
   task automatic drain_results();
      @(negedge clock) req_valid = 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int unsigned value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = CSRD_W'(value);
      do @(posedge clock); while (!csr_ready);
      unique case (idx)
         CSR_MIN_FRAG:  cfg_min_frag = FRAG_W'(value);
         CSR_MIN_MAPQ:  cfg_min_mapq = MAPQ_W'(value);
         CSR_MIN_IDENT: cfg_min_ident = IDENT_W'(value);
         CSR_TARGET:    cfg_target = COV_W'(value);
         CSR_CHROM_LEN: cfg_chrom_len = SPAN_W'(value);
         default: ;
      endcase
      @(negedge clock) csr_valid = 1'b0;
   endtask

   // Reset thresholds: each filter exactly at and just under its minimum
   task automatic test_quality_filters();
      verdict_type v;
      offer_cmd(make_read(100, 5, 9000, 0, 20), v);
      offer_cmd(make_read(99, 5, 9000, 0, 20), v);
      offer_cmd(make_read(100, 4, 9000, 0, 20), v);
      offer_cmd(make_read(100, 5, 8999, 0, 20), v);
      offer_cmd(make_read(1048575, 255, 10000, 0, 25), v);
   endtask

   // Clipped, empty, reversed and just-too-short spans
   task automatic test_span_handling();
      verdict_type v;
      offer_cmd(make_read(200, 20, 9500, 1048576, 1048576), v);
      offer_cmd(make_read(200, 20, 9500, 60, 40), v);
      offer_cmd(make_read(200, 20, 9500, 100, 119), v);
      offer_cmd(make_read(200, 20, 9500, 1000, 1048576), v);
   endtask

   // Low cap so spans fill up after a couple of reads
   task automatic test_coverage_cap();
      verdict_type v;
      drain_results();
      write_reg(CSR_TARGET, 2);
      write_reg(CSR_CHROM_LEN, 64);
      offer_cmd(make_read(150, 9, 9900, 0, 25), v);
      offer_cmd(make_read(150, 9, 9900, 20, 45), v);
      offer_cmd(make_read(150, 9, 9900, 20, 45), v);
      offer_cmd(make_read(150, 9, 9900, 20, 45), v);
      offer_cmd(make_read(150, 9, 9900, 40, 100), v);
   endtask

   // Reach the depth goal, get ignored, clear; then a goal of zero and a one-base chromosome
   task automatic test_target_goal();
      verdict_type v;
      drain_results();
      write_reg(CSR_CHROM_LEN, 50);
      write_reg(CSR_TARGET, 1);
      write_reg(CSR_MIN_FRAG, 0);
      offer_cmd(make_start(), v);
      offer_cmd(make_read(30, 9, 9900, 0, 25), v);
      offer_cmd(make_read(25, 9, 9900, 25, 50), v);
      offer_cmd(make_read(25, 9, 9900, 0, 50), v);
      offer_cmd(make_start(), v);
      drain_results();
      write_reg(CSR_TARGET, 0);
      offer_cmd(make_read(500, 9, 9900, 0, 40), v);
      offer_cmd(make_start(), v);
      drain_results();
      write_reg(CSR_TARGET, 1);
      write_reg(CSR_CHROM_LEN, 1);
      offer_cmd(make_read(500, 9, 9900, 0, 1), v);
   endtask

   // Thresholds at their top and bottom values
   task automatic test_config_extremes();
      verdict_type v;
      drain_results();
      write_reg(CSR_MIN_FRAG, 1048575);
      write_reg(CSR_MIN_MAPQ, 255);
      write_reg(CSR_MIN_IDENT, 10000);
      write_reg(CSR_TARGET, 255);
      write_reg(CSR_CHROM_LEN, 1048576);
      offer_cmd(make_start(), v);
      offer_cmd(make_read(1048575, 255, 10000, 0, 30), v);
      offer_cmd(make_read(1048574, 255, 10000, 0, 30), v);
      drain_results();
      write_reg(CSR_MIN_FRAG, 0);
      write_reg(CSR_MIN_MAPQ, 0);
      write_reg(CSR_MIN_IDENT, 0);
      offer_cmd(make_read(0, 0, 0, 100, 130), v);
   endtask

   // Random settings per phase, mostly well-formed reads with some noise
   task automatic test_random_mix();
      verdict_type  v;
      read_cmd_type cmd;
      int           live;
      int           r;
      int unsigned  lim;
      int unsigned  s;
      int unsigned  len;
      for (int phase = 0; phase < 4; phase++) begin
         drain_results();
         calm = (phase == 2);
         write_reg(CSR_MIN_FRAG, $urandom_range(0, 300));
         write_reg(CSR_MIN_MAPQ, $urandom_range(0, 40));
         write_reg(CSR_MIN_IDENT, $urandom_range(8000, 9900));
         write_reg(CSR_TARGET, $urandom_range(1, 6));
         r = $urandom_range(0, 99);
         if (r < 15) write_reg(CSR_CHROM_LEN, $urandom_range(1, 31));
         else if (r < 70) write_reg(CSR_CHROM_LEN, $urandom_range(32, 1024));
         else write_reg(CSR_CHROM_LEN, $urandom_range(1025, 1048576));
         offer_cmd(make_start(), v);
         live = 0;
         while (live < 16) begin
            lim = (cfg_chrom_len < STORE_DEPTH) ? cfg_chrom_len : STORE_DEPTH;
            r = $urandom_range(0, 99);
            if ((goal_met && r < 70) || r < 3) begin
               cmd = make_start();
            end else if (r < 15) begin
               // noise: any field value, spans often running off the end
               s = ($urandom_range(0, 1)) ? $urandom_range(0, lim)
                                          : $urandom_range(0, 1048576);
               cmd = make_read($urandom_range(0, 1048575), $urandom_range(0, 255),
                               $urandom_range(0, 10000), s, $urandom_range(0, 1048576));
            end else begin
               s = $urandom_range(0, (lim > 20) ? lim - 20 : 0);
               len = ($urandom_range(0, 9) < 8) ? $urandom_range(20, 60)
                                               : $urandom_range(20, 300);
               cmd = make_read($urandom_range(cfg_min_frag, cfg_min_frag + 50),
                               $urandom_range(cfg_min_mapq, 255),
                               $urandom_range(cfg_min_ident, 10000), s, s + len);
            end
            offer_cmd(cmd, v);
            if (v != VERDICT_TARGET) live++;
         end
      end
      calm = 1'b0;
   endtask

   // Pile more than 200 reads on one window so the counters hit their ceiling
   task automatic test_saturation();
      verdict_type  v;
      read_cmd_type cmd;
      int           hits;
      int unsigned  s;
      drain_results();
      write_reg(CSR_MIN_FRAG, 0);
      write_reg(CSR_MIN_MAPQ, 0);
      write_reg(CSR_MIN_IDENT, 0);
      write_reg(CSR_TARGET, 201);
      write_reg(CSR_CHROM_LEN, 1048576);
      offer_cmd(make_start(), v);
      hits = 0;
      while (hits < 205) begin
         calm = (hits < 100);
         if ($urandom_range(0, 19) == 0) begin
            s = $urandom_range(100, 900);
            cmd = make_read($urandom_range(0, 65535), $urandom_range(0, 255),
                            $urandom_range(0, 10000), s, s + $urandom_range(20, 40));
         end else begin
            cmd = make_read($urandom_range(0, 65535), $urandom_range(0, 255),
                            $urandom_range(0, 10000), $urandom_range(0, 4),
                            $urandom_range(24, 30));
            hits++;
         end
         offer_cmd(cmd, v);
      end
      calm = 1'b0;
      // a cap of 200 must now see the saturated window as full
      drain_results();
      write_reg(CSR_TARGET, 200);
      offer_cmd(make_read(500, 0, 0, 0, 30), v);
   endtask

   // Stall the result channel in random runs, short mostly, sometimes long
   initial begin
      int run;
      bit hold;
      int r;
      rsp_stall = 1'b0;
      run = 0;
      hold = 1'b0;
      forever begin
         @(negedge clock);
         if (run == 0) begin
            r = $urandom_range(0, 99);
            if (calm || r < 55) begin
               hold = 1'b0;
               run = calm ? 1 : $urandom_range(1, 6);
            end else if (r < 90) begin
               hold = 1'b1;
               run = $urandom_range(1, 3);
            end else begin
               hold = 1'b1;
               run = $urandom_range(15, 50);
            end
         end
         run--;
         rsp_stall = hold;
      end
   end

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      verdict_rec_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: result with nothing pending: verdict %0d reached %0d bases %0d",
                     $time, rsp_verdict, rsp_target_reached, rsp_accepted_bases);
            mismatches++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_verdict !== want.verdict) begin
               $display("%0t: verdict expected %0d actual %0d",
                        $time, want.verdict, rsp_verdict);
               mismatches++;
            end
            if (rsp_target_reached !== want.reached) begin
               $display("%0t: target_reached expected %0d actual %0d",
                        $time, want.reached, rsp_target_reached);
               mismatches++;
            end
            if (rsp_accepted_bases !== want.bases) begin
               $display("%0t: accepted_bases expected %0d actual %0d",
                        $time, want.bases, rsp_accepted_bases);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #40_000_000;
      $display("%0t: timeout with %0d results outstanding", $time, pending_verdicts.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      req_valid = 1'b0;
      req_opcode = 1'b0;
      req_fragment_length = '0;
      req_mapping_quality = '0;
      req_identity_centi = '0;
      req_span_start = '0;
      req_span_end = '0;
      csr_valid = 1'b0;
      csr_index = CSR_MIN_FRAG;
      csr_wdata = '0;
      calm = 1'b0;
      mismatches = 0;
      foreach (cov_depth[i]) cov_depth[i] = '0;
      base_sum = 0;
      goal_met = 1'b0;
      cfg_min_frag = RST_MIN_FRAG;
      cfg_min_mapq = RST_MIN_MAPQ;
      cfg_min_ident = RST_MIN_IDENT;
      cfg_target = RST_TARGET;
      cfg_chrom_len = RST_CHROM_LEN;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      test_quality_filters();
      test_span_handling();
      test_coverage_cap();
      test_target_goal();
      test_config_extremes();
      test_random_mix();
      test_saturation();

      // drain, then watch for stray results
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending_verdicts.size());
         mismatches++;
      end
      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
